[hw/rtl/sida_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared package
// Character codes, digit sizing and the status bundle of the item queue.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int DIGIT_W       = 4;
  localparam int BITS_PER_STEP = 4;
  localparam int CHAR_W        = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Decimal digits of 2^(w-1), using 1233/4096 as an estimate of log10(2).
  function automatic int num_digits(input int w);
    return (((w - 1) * 1233) >> 12) + 1;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sida_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal text: front end
// Takes a value, forms sign and magnitude and converts the magnitude to BCD
// by double dabble, four bits per cycle, then hands the result to the queue.
// ----------------------------------------------------------------------------
module sida_front
  import sida_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int ND          = 10,
  parameter int IW          = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire        [VALUE_WIDTH-1:0]   in_value,
  output logic                           busy,
  input  wire q_status_t                 q_status,
  output logic                           q_push,
  output logic       [ND*DIGIT_W+IW:0]   q_data
);

  localparam int NSTEP = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PW    = NSTEP * BITS_PER_STEP;
  localparam int BW    = ND * DIGIT_W;
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } f_state_t;

  f_state_t           state_r, state_nxt;
  logic [PW-1:0]      mag_r, mag_nxt;
  logic [BW-1:0]      bcd_r, bcd_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic               neg_r, neg_nxt;
  logic [PW-1:0]      mag_step;
  logic [BW-1:0]      bcd_step;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [IW-1:0]      msd;

  assign mag_in = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  always_comb begin
    bcd_step = bcd_r;
    mag_step = mag_r;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_step[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_step[d*DIGIT_W +: DIGIT_W] = bcd_step[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BW-2:0], mag_step[PW-1]};
      mag_step = {mag_step[PW-2:0], 1'b0};
    end
  end

  always_comb begin
    msd = '0;
    for (int d = 0; d < ND; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] != 4'd0) begin
        msd = IW'(d);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          neg_nxt   = in_value[VALUE_WIDTH-1];
          mag_nxt   = PW'(mag_in);
          bcd_nxt   = '0;
          step_nxt  = SW'(NSTEP - 1);
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        mag_nxt  = mag_step;
        bcd_nxt  = bcd_step;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_status.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
  end

  assign busy   = (state_r != F_IDLE);
  assign q_data = {neg_r, msd, bcd_r};

endmodule
`default_nettype wire

[hw/rtl/sida_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal text: item queue
// Two-entry queue of converted values between the front and back ends.
// ----------------------------------------------------------------------------
module sida_queue
  import sida_pkg::*;
#(
  parameter int DATA_W = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire  [DATA_W-1:0]  push_data,
  input  wire                pop,
  output logic [DATA_W-1:0]  pop_data,
  output q_status_t          status
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  // The front end must never write a full queue, nor the back end read an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("queue read while empty");

endmodule
`default_nettype wire

[hw/rtl/sida_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal text: back end
// Takes converted values from the queue and sends their text one character
// per cycle, a minus sign first for a negative value, then digits from the
// most significant one.
module sida_back
  import sida_pkg::*;
#(
  parameter int ND = 10,
  parameter int IW = 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire q_status_t              q_status,
  input  wire  [ND*DIGIT_W+IW:0]      q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [CHAR_W-1:0]           out_ascii_char,
  output logic                        out_last_char
);

  localparam int BW = ND * DIGIT_W;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SIGN  = 3'b010,
    B_DIGIT = 3'b100
  } b_state_t;

  b_state_t          state_r, state_nxt;
  logic [BW-1:0]     bcd_r, bcd_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              can_load;
  logic [DIGIT_W-1:0] digit;

  assign digit    = bcd_r[idx_r*DIGIT_W +: DIGIT_W];
  assign can_load = (state_r == B_IDLE) || ((state_r == B_DIGIT) && (idx_r == '0));
  assign q_pop    = can_load && !q_status.empty;

  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = 1'b0;
    case (state_r)
      B_IDLE: begin
      end
      B_SIGN: begin
        valid_nxt = 1'b1;
        char_nxt  = CHAR_MINUS;
        state_nxt = B_DIGIT;
      end
      B_DIGIT: begin
        valid_nxt = 1'b1;
        char_nxt  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        last_nxt  = (idx_r == '0);
        idx_nxt   = idx_r - 1'b1;
        if (idx_r == '0) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    if (q_pop) begin
      bcd_nxt   = q_data[BW-1:0];
      idx_nxt   = q_data[BW +: IW];
      state_nxt = q_data[BW+IW] ? B_SIGN : B_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    bcd_r  <= bcd_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_ascii_char = char_r;
  assign out_last_char  = last_r;

  // A minus sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (char_r == CHAR_MINUS)) |-> !last_r)
    else $error("minus sign marked as last character");

  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (char_r == CHAR_MINUS)) |=> (valid_r && (char_r != CHAR_MINUS)))
    else $error("minus sign not followed by a digit");

endmodule
`default_nettype wire

[hw/rtl/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal text
// Turns a two's complement value into its decimal ASCII characters.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. The front end converts
// it to BCD by double dabble at four bits per cycle. Busy then stays high
// through the conversion and the push into the two-entry queue towards the
// back end; if that queue is full, busy stays high until a slot frees up. A
// new value can be taken while the back end still sends the text of an earlier
// one. The back end sends the text one character per cycle on out_valid: a
// '-' for a negative value, then the digits from the most significant one
// without leading zeros, with out_last_char set on the final digit. A value
// yields 1 to 11 characters at 32 bits; the sustained rate is set by the
// slower of the conversion and the character stream. Every character is valid
// for exactly one cycle; the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  signed [VALUE_WIDTH-1:0] in_value,
  output logic                         busy,
  output logic                         out_valid,
  output logic [CHAR_W-1:0]            out_ascii_char,
  output logic                         out_last_char
);

  localparam int ND = num_digits(VALUE_WIDTH);
  localparam int IW = $clog2(ND);
  localparam int QW = ND * DIGIT_W + IW + 1;

  q_status_t       q_status;
  logic            q_push;
  logic            q_pop;
  logic [QW-1:0]   q_wdata;
  logic [QW-1:0]   q_rdata;

  sida_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .ND          (ND),
    .IW          (IW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_value (in_value),
    .busy     (busy),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  sida_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .status    (q_status)
  );

  sida_back #(
    .ND (ND),
    .IW (IW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char)
  );

endmodule
`default_nettype wire
